FILE: rtl/core/crc8cld_pkg.sv
// ----------------------------------------------------------------------------
// crc8cld_pkg
// Shared types, constants and helper functions of the CRC-8 checked line
// deframer.
// ----------------------------------------------------------------------------
package crc8cld_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

  localparam logic [8:0] CAP_RESET = 9'd256;

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] CHAR_SEP = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic RES_VERDICT = 1'b0;
  localparam logic RES_READ    = 1'b1;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_DROPPED = 2'd1,
    ST_FORMAT  = 2'd2,
    ST_CRC     = 2'd3
  } frame_status_t;

  // One result request as it leaves the line state logic.
  typedef struct packed {
    logic          valid;
    logic          kind;
    frame_status_t status;
    logic [8:0]    plen;
    logic          oob;
  } res_req_t;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = 8'h30 + {4'd0, n};
    else           r = 8'h61 + {4'd0, n} - 8'd10;
    return r;
  endfunction

  function automatic logic is_lower_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66));
  endfunction

endpackage

FILE: rtl/core/crc8cld_ram.sv
// ----------------------------------------------------------------------------
// crc8cld_ram
// Single write port, single read port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module crc8cld_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/crc8cld_frame.sv
// ----------------------------------------------------------------------------
// crc8cld_frame
// Line state: fill count, drop flag, running CRC, separator tracking and the
// verdict at LF. Drives the buffer write and read ports.
// ----------------------------------------------------------------------------
module crc8cld_frame import crc8cld_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [8:0]        cfg_wdata,
  input  logic              accept,
  input  logic [1:0]        kind,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        read_index,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [7:0]        mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr,
  output res_req_t          req
);

  logic [8:0]       cap_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             drop_r, drop_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       crc_sep_r, crc_sep_nxt;
  logic             sep_seen_r, sep_seen_nxt;
  logic [CNT_W-1:0] sep_pos_r, sep_pos_nxt;
  logic [15:0]      last2_r, last2_nxt;

  logic [CNT_W-1:0] cap_eff;
  frame_status_t    verdict;
  logic [8:0]       verdict_plen;
  logic             do_empty;

  assign cap_eff = (CNT_W'(cap_r) < CNT_W'(BUFFER_DEPTH)) ? CNT_W'(cap_r)
                                                            : CNT_W'(BUFFER_DEPTH);

  always_comb begin
    verdict_plen = '0;
    if (drop_r) begin
      verdict = ST_DROPPED;
    end else if (!sep_seen_r || (sep_pos_r == '0) ||
                 ({1'b0, fill_r} != ({1'b0, sep_pos_r} + (CNT_W+1)'(3)))) begin
      verdict = ST_FORMAT;
    end else if (!is_lower_hex(last2_r[15:8]) || !is_lower_hex(last2_r[7:0])) begin
      verdict = ST_FORMAT;
    end else if ((last2_r[15:8] != hex_char(crc_sep_r[7:4])) ||
                 (last2_r[7:0] != hex_char(crc_sep_r[3:0]))) begin
      verdict = ST_CRC;
    end else begin
      verdict      = ST_VALID;
      verdict_plen = 9'(sep_pos_r);
    end
  end

  always_comb begin
    fill_nxt     = fill_r;
    drop_nxt     = drop_r;
    crc_nxt      = crc_r;
    crc_sep_nxt  = crc_sep_r;
    sep_seen_nxt = sep_seen_r;
    sep_pos_nxt  = sep_pos_r;
    last2_nxt    = last2_r;
    do_empty     = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    req          = '0;
    req.status   = ST_VALID;
    if (accept) begin
      unique case (kind)
        KIND_READ: begin
          mem_re   = 1'b1;
          req.valid = 1'b1;
          req.kind  = RES_READ;
          req.oob   = (32'(read_index) >= BUFFER_DEPTH);
        end
        KIND_CLEAR: begin
          drop_nxt = 1'b0;
          do_empty = 1'b1;
        end
        KIND_PUSH: begin
          if (rx_byte == CHAR_LF) begin
            req.valid  = 1'b1;
            req.kind   = RES_VERDICT;
            req.status = verdict;
            req.plen   = verdict_plen;
            drop_nxt   = 1'b0;
            do_empty   = 1'b1;
          end else if ((rx_byte == CHAR_CR) || drop_r) begin
            // Ignored byte.
          end else if (fill_r >= cap_eff) begin
            drop_nxt = 1'b1;
            do_empty = 1'b1;
          end else begin
            if (rx_byte == CHAR_SEP) begin
              crc_sep_nxt  = crc_r;
              sep_seen_nxt = 1'b1;
              sep_pos_nxt  = fill_r;
            end
            mem_we    = 1'b1;
            crc_nxt   = crc_update(crc_r, rx_byte);
            last2_nxt = {last2_r[7:0], rx_byte};
            fill_nxt  = fill_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
    if (do_empty) begin
      fill_nxt     = '0;
      crc_nxt      = '0;
      crc_sep_nxt  = '0;
      sep_seen_nxt = 1'b0;
      sep_pos_nxt  = '0;
      last2_nxt    = '0;
    end
  end

  // Fill count never exceeds the buffer depth while a byte is stored.
  assign mem_waddr = fill_r[ADDR_W-1:0];
  assign mem_wdata = rx_byte;
  assign mem_raddr = ADDR_W'(read_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_RESET;
      fill_r     <= '0;
      drop_r     <= 1'b0;
      crc_r      <= '0;
      crc_sep_r  <= '0;
      sep_seen_r <= 1'b0;
      sep_pos_r  <= '0;
      last2_r    <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      fill_r     <= fill_nxt;
      drop_r     <= drop_nxt;
      crc_r      <= crc_nxt;
      crc_sep_r  <= crc_sep_nxt;
      sep_seen_r <= sep_seen_nxt;
      sep_pos_r  <= sep_pos_nxt;
      last2_r    <= last2_nxt;
    end
  end

endmodule

FILE: rtl/core/crc8cld_outq.sv
// ----------------------------------------------------------------------------
// crc8cld_outq
// Result path: a stage that lines the request up with the RAM read data,
// followed by the output register.
// ----------------------------------------------------------------------------
module crc8cld_outq import crc8cld_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  res_req_t   req,
  input  logic [7:0] mem_rdata,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_result_kind,
  output logic [1:0] out_frame_status,
  output logic [8:0] out_payload_length,
  output logic [7:0] out_read_data
);

  res_req_t   s1_r;
  logic       s1_valid_r;
  logic       s1_adv;
  logic       out_valid_r;
  logic       out_kind_r;
  logic [1:0] out_status_r;
  logic [8:0] out_plen_r;
  logic [7:0] out_data_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && req.valid) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.valid) begin
      s1_r <= req;
    end
    if (s1_adv) begin
      out_kind_r   <= s1_r.kind;
      out_status_r <= s1_r.status;
      out_plen_r   <= s1_r.plen;
      // The RAM output register is only loaded by reads, so it still holds
      // this request's byte even if pushes went by meanwhile.
      out_data_r   <= ((s1_r.kind == RES_READ) && !s1_r.oob) ? mem_rdata : 8'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_frame_status   = out_status_r;
  assign out_payload_length = out_plen_r;
  assign out_read_data      = out_data_r;

endmodule

FILE: rtl/core/crc8_checked_line_deframer.sv
// Result path: a result (verdict at LF or read data) is registered in the
//   request stage and then in the output register; a stalled output holds it.
// Throughput: one request per cycle while the output is not stalled; in_stall
//   holds the input while a result waits in the request stage.
// Reset: synchronous, active low; line state empty, capacity 256. The line
//   buffer contents are not cleared.
// ----------------------------------------------------------------------------
// crc8_checked_line_deframer
// Top level of the CRC-8 checked line deframer.
// ----------------------------------------------------------------------------
module crc8_checked_line_deframer import crc8cld_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_result_kind,
  output logic [1:0] out_frame_status,
  output logic [8:0] out_payload_length,
  output logic [7:0] out_read_data
);

  logic              accept;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  res_req_t          req;

  assign accept = in_valid && !in_stall;

  crc8cld_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .kind       (in_kind),
    .rx_byte    (in_rx_byte),
    .read_index (in_read_index),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .req        (req)
  );

  crc8cld_ram #(
    .DEPTH (BUFFER_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  crc8cld_outq u_outq (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (accept),
    .req                (req),
    .mem_rdata          (mem_rdata),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_frame_status   (out_frame_status),
    .out_payload_length (out_payload_length),
    .out_read_data      (out_read_data)
  );

endmodule

FILE: rtl/core/crc8cld_checker.sv
// ----------------------------------------------------------------------------
// crc8cld_checker
// Port level checks of the CRC-8 checked line deframer, bound to the top.
// ----------------------------------------------------------------------------
module crc8cld_checker import crc8cld_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_result_kind,
  input logic [1:0] out_frame_status,
  input logic [8:0] out_payload_length,
  input logic [7:0] out_read_data
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_frame_status) && $stable(out_payload_length) && $stable(out_read_data))
    else $error("result changed while stalled");

  // Nothing is presented in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A rejected or dropped line reports no length.
  a_bad_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RES_VERDICT) && (out_frame_status != ST_VALID)
      |-> (out_payload_length == 9'd0))
    else $error("length reported on a bad line");

  // A valid line has a separator past position zero.
  a_good_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RES_VERDICT) && (out_frame_status == ST_VALID)
      |-> (out_payload_length != 9'd0))
    else $error("valid line with empty payload");

  // Read results carry only data.
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RES_READ)
      |-> (out_frame_status == ST_VALID) && (out_payload_length == 9'd0))
    else $error("read result with verdict fields set");

endmodule

bind crc8_checked_line_deframer crc8cld_checker u_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_result_kind    (out_result_kind),
  .out_frame_status   (out_frame_status),
  .out_payload_length (out_payload_length),
  .out_read_data      (out_read_data)
);
